@@ hdl/spr_pkg.sv @@
// Package: shared types, constants and the arctangent table for the reachability check.
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

  localparam int COORD_WIDTH_DEF  = 15;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ARM_W            = 13;
  localparam int MODE_W           = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int ANG_W            = 24;
  localparam int DP_W             = 66;

  localparam logic [ARM_W-1:0] ARM_RESET  = 13'd3200;
  localparam logic [7:0]       MODE_MAX   = 8'd3;
  localparam logic [31:0]      RADIUS_SQ_LIMIT = 32'd40960000;
  localparam int               Z_LOW      = 160;
  localparam int               Z_HIGH     = 3760;
  localparam logic [ANG_W-1:0] J1_LIMIT   = 24'd91506;
  localparam logic [ANG_W-1:0] J2_LIMIT   = 24'd154416;
  localparam logic [ANG_W-1:0] HALF_PI_Q16 = 24'd102944;
  localparam logic [16:0]      GAIN_INV_Q16 = 17'd39797;
  localparam int               NORM_BIT   = 40;

  typedef enum logic [1:0] {
    CFG_INNER = 2'd0,
    CFG_OUTER = 2'd1,
    CFG_HAND  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RSN_OK     = 3'd0,
    RSN_MODE   = 3'd1,
    RSN_RADIUS = 3'd2,
    RSN_Z      = 3'd3,
    RSN_JOINT  = 3'd4
  } reason_t;

  // classified job handed from front to back
  typedef struct packed {
    logic              need_ik;
    reason_t           reason;
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic [48:0]       r2;
  } job_t;

  typedef struct packed {
    logic    valid_res;
    reason_t reason;
  } res_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_MUL, BK_CHK, BK_SQRT, BK_AT_A, BK_AT_P, BK_J1,
    BK_ROT, BK_AT_E, BK_J2, BK_DONE
  } bk_state_t;

  function automatic logic [ANG_W-1:0] atan_tab(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    begin
      case (i)
        5'd0: v = 24'd51472;  5'd1: v = 24'd30386;  5'd2: v = 24'd16055;
        5'd3: v = 24'd8150;   5'd4: v = 24'd4091;   5'd5: v = 24'd2047;
        5'd6: v = 24'd1024;   5'd7: v = 24'd512;    5'd8: v = 24'd256;
        5'd9: v = 24'd128;    5'd10: v = 24'd64;    5'd11: v = 24'd32;
        5'd12: v = 24'd16;    5'd13: v = 24'd8;     5'd14: v = 24'd4;
        5'd15: v = 24'd2;     5'd16: v = 24'd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/scara_pose_reachability_check.sv @@
// Top level: SCARA pose reachability check, queue-style channels.
//
//  channel  ports                                   handshake
//  input    in_mode, in_target_x/y/z                in_push, in_full
//  result   out_valid_res, out_reason               out_empty, out_pop
//  config   cfg_index, cfg_data                     cfg_we
//
// A command with a bad mode or failing radius/height passes the front stages and
// the job queue; the back end only hands its verdict to the result queue. A full
// joint check holds the back end through a multiply, a square root, three atan2
// passes (each with its pre-scale doublings) and a rotation; this sets
// throughput, as the back end takes one job at a time. The front classifies
// the next beats while the back works; a 4-deep job queue and a 2-deep result
// queue let each side stall alone. Synchronous active-low reset clears all control.
`timescale 1ns / 1ps
`default_nettype none
module scara_pose_reachability_check #(
  parameter int COORD_WIDTH  = spr_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = spr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_push,
  output logic                        in_full,
  input  wire  [spr_pkg::MODE_W-1:0]  in_mode,
  input  wire  [COORD_WIDTH-1:0]      in_target_x,
  input  wire  [COORD_WIDTH-1:0]      in_target_y,
  input  wire  [COORD_WIDTH-1:0]      in_target_z,
  output logic                        out_empty,
  input  wire                         out_pop,
  output logic                        out_valid_res,
  output logic [2:0]                  out_reason,
  input  wire                         cfg_we,
  input  wire  [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [spr_pkg::ARM_W-1:0]   cfg_data
);
  import spr_pkg::*;

  logic [ARM_W-1:0] inner_r, outer_r;
  logic             hand_r;
  logic             fj_valid, fj_ready, jq_full, jq_empty, jq_pop;
  job_t             fj, jq_out;
  logic             rs_push, rq_full;
  res_t             rs, rq_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= ARM_RESET;
      outer_r <= ARM_RESET;
      hand_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INNER: inner_r <= cfg_data;
        CFG_OUTER: outer_r <= cfg_data;
        CFG_HAND:  hand_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  spr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_mode, .in_target_x, .in_target_y,
    .in_target_z, .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  assign fj_ready = !jq_full;

  spr_fifo #(.W($bits(job_t)), .DEPTH(4)) u_jobq (
    .clk, .rst_n, .wr_en(fj_valid), .wr_data(fj), .full(jq_full),
    .rd_en(jq_pop), .rd_data(jq_out), .empty(jq_empty)
  );

  spr_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .inner_r, .outer_r, .hand_r, .job_empty(jq_empty),
    .job_pop(jq_pop), .job(jq_out), .res_push(rs_push), .res_full(rq_full), .res(rs)
  );

  spr_fifo #(.W($bits(res_t)), .DEPTH(2)) u_resq (
    .clk, .rst_n, .wr_en(rs_push), .wr_data(rs), .full(rq_full),
    .rd_en(out_pop), .rd_data(rq_out), .empty(out_empty)
  );

  assign out_valid_res = rq_out.valid_res;
  assign out_reason    = rq_out.reason;

`ifndef SYNTHESIS
  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_valid_res == (out_reason == RSN_OK)))
    else $error("valid_res disagrees with reason");
  a_no_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    jq_pop |-> !jq_empty)
    else $error("back end popped an empty job queue");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    rs_push |-> !rq_full)
    else $error("result pushed into full queue");
`endif
endmodule
`default_nettype wire

@@ hdl/spr_front.sv @@
// Front end: sign extension, mode, radius and height checks.
`timescale 1ns / 1ps
`default_nettype none
module spr_front #(
  parameter int COORD_WIDTH = spr_pkg::COORD_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire  [spr_pkg::MODE_W-1:0]   in_mode,
  input  wire  [COORD_WIDTH-1:0]       in_target_x,
  input  wire  [COORD_WIDTH-1:0]       in_target_y,
  input  wire  [COORD_WIDTH-1:0]       in_target_z,
  output logic                         job_valid,
  input  wire                          job_ready,
  output spr_pkg::job_t                job
);
  import spr_pkg::*;

  // stage 1: capture and square
  logic               s1_v_r;
  logic [MODE_W-1:0]  s1_mode_r;
  logic signed [24:0] s1_x_r, s1_y_r, s1_z_r;
  // stage 2: classify
  logic               s2_v_r;
  job_t               s2_job_r;
  logic [48:0]        xx, yy, r2;
  logic               adv2, adv1;
  reason_t            rsn;

  assign adv2 = !s2_v_r || job_ready;
  assign adv1 = !s1_v_r || adv2;
  assign in_full = !adv1;

  assign xx = 49'($signed(s1_x_r) * $signed(s1_x_r));
  assign yy = 49'($signed(s1_y_r) * $signed(s1_y_r));
  assign r2 = xx + yy;

  always_comb begin
    if (s1_mode_r > MODE_MAX)                    rsn = RSN_MODE;
    else if (r2 >= 49'(RADIUS_SQ_LIMIT))         rsn = RSN_RADIUS;
    else if (!(s1_z_r > 25'(Z_LOW) && s1_z_r < 25'(Z_HIGH))) rsn = RSN_Z;
    else                                          rsn = RSN_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_push;
      if (adv2) s2_v_r <= s1_v_r;
    end
    if (adv1 && in_push) begin
      s1_mode_r <= in_mode;
      s1_x_r <= 25'($signed(in_target_x));
      s1_y_r <= 25'($signed(in_target_y));
      s1_z_r <= 25'($signed(in_target_z));
    end
    if (adv2 && s1_v_r) begin
      s2_job_r.need_ik <= (rsn == RSN_OK);
      s2_job_r.reason  <= rsn;
      s2_job_r.x       <= s1_x_r;
      s2_job_r.y       <= s1_y_r;
      s2_job_r.r2      <= r2;
    end
  end

  assign job_valid = s2_v_r;
  assign job = s2_job_r;
endmodule
`default_nettype wire

@@ hdl/spr_fifo.sv @@
// Small register queue, used for the job queue between the front and back ends and for the result queue.
`timescale 1ns / 1ps
`default_nettype none
module spr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          wr_en,
  input  wire  [W-1:0] wr_data,
  output logic         full,
  input  wire          rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

@@ hdl/spr_cordic.sv @@
// Shared iterative CORDIC: vectoring (atan2) and rotation, one step a cycle.
`timescale 1ns / 1ps
`default_nettype none
module spr_cordic #(
  parameter int CORDIC_STEPS = spr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            start,
  input  wire                            rotate,
  input  wire  signed [spr_pkg::DP_W-1:0] x_in,
  input  wire  signed [spr_pkg::DP_W-1:0] y_in,
  input  wire  signed [spr_pkg::ANG_W-1:0] ang_in,
  output logic                           done,
  output logic signed [spr_pkg::ANG_W-1:0] ang_out,
  output logic signed [spr_pkg::DP_W-1:0]  x_out,
  output logic signed [spr_pkg::DP_W-1:0]  y_out
);
  import spr_pkg::*;
  localparam int NST = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  typedef enum logic [1:0] {CD_IDLE, CD_NORM, CD_ITER, CD_DONE} cd_t;
  cd_t st_r, st_nxt;
  logic signed [DP_W-1:0]  x_r, y_r;
  logic signed [ANG_W-1:0] acc_r;
  logic                    rot_r;
  logic [4:0]              i_r;
  logic signed [DP_W-1:0]  xs, ys, ax, ay;
  logic                    big, dir;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign ax = x_r[DP_W-1] ? -x_r : x_r;
  assign ay = y_r[DP_W-1] ? -y_r : y_r;
  assign big = (ax[DP_W-2:NORM_BIT] != '0) || (ay[DP_W-2:NORM_BIT] != '0);
  // rotation turns toward the residual angle, vectoring drives y to zero
  assign dir = rot_r ? !acc_r[ANG_W-1] : (y_r > 0);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      CD_IDLE: if (start) st_nxt = rotate ? CD_ITER : CD_NORM;
      CD_NORM: begin
        if (x_r == '0 && y_r == '0) st_nxt = CD_DONE;
        else if (big)               st_nxt = CD_ITER;
      end
      CD_ITER: if (i_r == 5'(NST-1)) st_nxt = CD_DONE;
      CD_DONE: st_nxt = start ? (rotate ? CD_ITER : CD_NORM) : CD_IDLE;
      default: st_nxt = CD_IDLE;
    endcase
  end

  always_comb begin
    done = (st_r == CD_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= CD_IDLE;
    else        st_r <= st_nxt;
    case (st_r)
      CD_IDLE, CD_DONE: if (start) begin
        rot_r <= rotate;
        i_r   <= '0;
        if (rotate) begin
          x_r <= x_in; y_r <= y_in; acc_r <= ang_in;
        end else if (x_in < 0) begin
          if (y_in >= 0) begin
            x_r <= y_in; y_r <= -x_in; acc_r <= HALF_PI_Q16;
          end else begin
            x_r <= -y_in; y_r <= x_in; acc_r <= -HALF_PI_Q16;
          end
        end else begin
          x_r <= x_in; y_r <= y_in; acc_r <= '0;
        end
      end
      CD_NORM: if (!big) begin
        x_r <= x_r <<< 1; y_r <= y_r <<< 1;
      end
      CD_ITER: begin
        i_r <= i_r + 5'd1;
        if (rot_r) begin
          if (dir) begin
            x_r <= x_r - ys; y_r <= y_r + xs; acc_r <= acc_r - atan_tab(i_r);
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; acc_r <= acc_r + atan_tab(i_r);
          end
        end else begin
          if (dir) begin
            x_r <= x_r + ys; y_r <= y_r - xs; acc_r <= acc_r + atan_tab(i_r);
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; acc_r <= acc_r - atan_tab(i_r);
          end
        end
      end
      default: ;
    endcase
  end

  // zero vector yields angle zero (the non-rotated start with both zero)
  assign ang_out = acc_r;
  assign x_out = x_r;
  assign y_out = y_r;
endmodule
`default_nettype wire

@@ hdl/spr_back.sv @@
// Back end: inverse kinematics sequencer with square root and shared CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module spr_back #(
  parameter int CORDIC_STEPS = spr_pkg::CORDIC_STEPS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  [spr_pkg::ARM_W-1:0] inner_r,
  input  wire  [spr_pkg::ARM_W-1:0] outer_r,
  input  wire                       hand_r,
  input  wire                       job_empty,
  output logic                      job_pop,
  input  wire  spr_pkg::job_t       job,
  output logic                      res_push,
  input  wire                       res_full,
  output spr_pkg::res_t             res
);
  import spr_pkg::*;

  bk_state_t st_r, st_nxt;
  job_t      job_r;
  logic signed [DP_W-1:0] n_r, p_r;
  logic [DP_W-1:0] lim_r, rem_r, root_r, bit_r;
  logic [ANG_W-1:0] ang_a_r, j1_r;
  logic [1:0] mstep_r;
  logic       ok_r, zero_r;
  logic [25:0] l1sq_r, l2sq_r;
  logic [DP_W-1:0] nabs;

  logic cd_start, cd_rot, cd_done;
  logic signed [DP_W-1:0] cd_x, cd_y, cd_xo, cd_yo;
  logic signed [ANG_W-1:0] cd_ang, cd_ao;
  logic signed [ANG_W-1:0] j1c, j2c;
  logic [ANG_W-1:0] j1a, j2a;
  logic [DP_W-1:0] trial;

  spr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cd_start), .rotate(cd_rot), .x_in(cd_x), .y_in(cd_y),
    .ang_in(cd_ang), .done(cd_done), .ang_out(cd_ao), .x_out(cd_xo), .y_out(cd_yo)
  );

  assign nabs  = n_r[DP_W-1] ? DP_W'(-n_r) : DP_W'(n_r);
  assign trial = root_r + bit_r;
  assign j1c = hand_r ? (cd_ao + $signed(ang_a_r)) : (cd_ao - $signed(ang_a_r));
  assign j1a = j1c[ANG_W-1] ? -j1c : j1c;
  assign j2c = cd_ao - $signed(j1_r);
  assign j2a = j2c[ANG_W-1] ? -j2c : j2c;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (!job_empty) st_nxt = job.need_ik ? BK_MUL : BK_DONE;
      BK_MUL:  if (mstep_r == 2'd3) st_nxt = BK_CHK;
      BK_CHK:  st_nxt = zero_r ? BK_DONE : BK_SQRT;
      BK_SQRT: if (bit_r == '0) st_nxt = BK_AT_A;
      BK_AT_A: if (cd_done) st_nxt = BK_AT_P;
      BK_AT_P: if (cd_done) st_nxt = BK_J1;
      BK_J1:   st_nxt = ok_r ? BK_ROT : BK_DONE;
      BK_ROT:  if (cd_done) st_nxt = BK_AT_E;
      BK_AT_E: if (cd_done) st_nxt = BK_DONE;
      BK_DONE: if (!res_full) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (st_r == BK_IDLE) && !job_empty;
    res_push = (st_r == BK_DONE) && !res_full;
    res.valid_res = (job_r.reason == RSN_OK);
    res.reason    = job_r.reason;
    cd_start = 1'b0; cd_rot = 1'b0; cd_x = '0; cd_y = '0; cd_ang = '0;
    case (st_r)
      BK_SQRT: if (bit_r == '0) begin
        cd_start = 1'b1; cd_x = n_r; cd_y = $signed(root_r);
      end
      BK_AT_A: if (cd_done) begin
        cd_start = 1'b1; cd_x = DP_W'(job_r.x); cd_y = DP_W'(job_r.y);
      end
      BK_J1: if (ok_r) begin
        cd_start = 1'b1; cd_rot = 1'b1; cd_ang = $signed(j1_r);
        cd_x = $signed(DP_W'(inner_r) * DP_W'(GAIN_INV_Q16));
      end
      BK_ROT: if (cd_done) begin
        cd_start = 1'b1;
        cd_x = (DP_W'(job_r.x) <<< 16) - cd_xo;
        cd_y = (DP_W'(job_r.y) <<< 16) - cd_yo;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else        st_r <= st_nxt;
    case (st_r)
      BK_IDLE: if (!job_empty) begin
        job_r <= job; mstep_r <= '0;
      end
      BK_MUL: begin
        mstep_r <= mstep_r + 2'd1;
        case (mstep_r)
          2'd0: begin
            l1sq_r <= inner_r * inner_r; l2sq_r <= outer_r * outer_r;
          end
          2'd1: begin
            n_r <= $signed(DP_W'(job_r.r2) + DP_W'(l1sq_r) - DP_W'(l2sq_r));
            lim_r <= DP_W'(l1sq_r) * DP_W'(job_r.r2[31:0]);
          end
          2'd2: begin
            p_r <= $signed(DP_W'({32'd0, nabs[31:0]} * {32'd0, nabs[31:0]}));
            lim_r <= lim_r << 2;
          end
          default: begin
            zero_r <= (job_r.r2 == '0) || (inner_r == '0) || (DP_W'(p_r) > lim_r);
            rem_r  <= lim_r - DP_W'(p_r);
            root_r <= '0;
            bit_r  <= DP_W'(1) << 62;
          end
        endcase
      end
      BK_CHK: if (zero_r) job_r.reason <= RSN_JOINT;
      BK_SQRT: if (bit_r != '0) begin
        bit_r <= bit_r >> 2;
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial; root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
      end
      BK_AT_A: if (cd_done) ang_a_r <= cd_ao;
      BK_AT_P: if (cd_done) begin
        j1_r <= j1c;
        ok_r <= (j1a < J1_LIMIT);
      end
      BK_J1: if (!ok_r) job_r.reason <= RSN_JOINT;
      BK_AT_E: if (cd_done && !(j2a < J2_LIMIT)) job_r.reason <= RSN_JOINT;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the SCARA pose reachability check: table-driven and random commands.
`timescale 1ns / 1ps
module tb;
  import spr_pkg::*;

  localparam int CW    = COORD_WIDTH_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [MODE_W-1:0] in_mode = '0;
  logic [CW-1:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_valid_res;
  logic [2:0] out_reason;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ARM_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  scara_pose_reachability_check dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_mode(in_mode),
    .in_target_x(in_target_x), .in_target_y(in_target_y), .in_target_z(in_target_z),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_valid_res(out_valid_res), .out_reason(out_reason),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the arm registers and a bit-exact fixed-point model
  // ---------------------------------------------------------------------------
  logic [ARM_W-1:0] arm_inner = 13'd3200;
  logic [ARM_W-1:0] arm_outer = 13'd3200;
  logic             hand_left = 1'b1;

  // atan(2^-i) in Q16, rounded; zero beyond step 16
  localparam longint ARCTAN_Q16 [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2,
                                         1, 0, 0, 0, 0, 0, 0, 0};
  localparam longint NORM_TOP = longint'(1) << 40;

  function automatic longint absl(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned sqrt_floor(input longint unsigned v);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  // vectoring mode: bearing of (x, y), quarter-turn pre-rotation for x < 0
  function automatic longint bearing_q16(input longint y, input longint x);
    longint acc, t, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 102944;
      end else begin
        x = -y; y = t; acc = -102944;
      end
    end
    while (absl(x) < NORM_TOP && absl(y) < NORM_TOP) begin
      x = x * 2; y = y * 2;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + ARCTAN_Q16[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ARCTAN_Q16[i];
      end
    end
    return acc;
  endfunction

  function automatic bit joints_in_limits(input longint x, input longint y, input longint r2);
    longint l1, l2, n, a, j1, j2, ex, ey, ang, xs, ys;
    longint unsigned lim, nsq;
    l1 = longint'(arm_inner);
    l2 = longint'(arm_outer);
    if (r2 == 0 || l1 == 0) return 1'b0;
    n = r2 + l1 * l1 - l2 * l2;
    lim = 4 * longint'(l1 * l1) * r2;
    nsq = longint'(absl(n)) * longint'(absl(n));
    if (nsq > lim) return 1'b0;
    a = bearing_q16(longint'(sqrt_floor(lim - nsq)), n);
    j1 = bearing_q16(y, x) + (hand_left ? a : -a);
    if (absl(j1) >= 91506) return 1'b0;
    // elbow point by rotation of the scaled inner link
    ex = l1 * 39797; ey = 0; ang = j1;
    for (int i = 0; i < STEPS; i++) begin
      xs = ex >>> i; ys = ey >>> i;
      if (ang >= 0) begin
        ex = ex - ys; ey = ey + xs; ang = ang - ARCTAN_Q16[i];
      end else begin
        ex = ex + ys; ey = ey - xs; ang = ang + ARCTAN_Q16[i];
      end
    end
    j2 = bearing_q16(y * 65536 - ey, x * 65536 - ex) - j1;
    return absl(j2) < 154416;
  endfunction

  function automatic res_t predict_pose(input logic [MODE_W-1:0] m, input logic signed [CW-1:0] sx,
                                        input logic signed [CW-1:0] sy,
                                        input logic signed [CW-1:0] sz);
    longint x, y, z, r2;
    res_t r;
    x = sx; y = sy; z = sz;
    r2 = x * x + y * y;
    if (m > 8'd3)                              r.reason = RSN_MODE;
    else if (r2 >= 40960000)                   r.reason = RSN_RADIUS;
    else if (!(z > 160 && z < 3760))           r.reason = RSN_Z;
    else if (!joints_in_limits(x, y, r2))      r.reason = RSN_JOINT;
    else                                       r.reason = RSN_OK;
    r.valid_res = (r.reason == RSN_OK);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Expected verdicts and the result-side monitor
  // ---------------------------------------------------------------------------
  res_t verdicts_due[$];
  int   fails = 0;
  int   verdicts_seen = 0;
  int   pass_seen = 0;

  // sampled mid-cycle so that the beat taken at the next rising edge is stable
  always @(negedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (verdicts_due.size() == 0) begin
        $error("result beat with nothing expected: valid_res %0b reason %0d",
               out_valid_res, out_reason);
        fails++;
      end else begin
        e = verdicts_due.pop_front();
        if (out_valid_res !== e.valid_res) begin
          $error("valid_res: expected %0b, got %0b", e.valid_res, out_valid_res);
          fails++;
        end
        if (out_reason !== e.reason) begin
          $error("reason: expected %0d, got %0d", e.reason, out_reason);
          fails++;
        end
        verdicts_seen++;
        if (e.reason == RSN_OK) pass_seen++;
      end
    end
  end

  // receiver: alternates stretches of steady pop with stretches of random stalls
  int pop_cycle = 0;
  always @(posedge clk) begin
    pop_cycle <= pop_cycle + 1;
    case ((pop_cycle / 97) % 3)
      0:       out_pop <= 1'b1;
      1:       out_pop <= ($urandom_range(0, 2) == 0);
      default: out_pop <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int cmds_sent = 0;

  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [CW-1:0] x,
                          input logic [CW-1:0] y, input logic [CW-1:0] z,
                          input bit typed, input res_t typed_res);
    bit taken;
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_push <= 1'b1;
    in_mode <= m; in_target_x <= x; in_target_y <= y; in_target_z <= z;
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
    verdicts_due.push_back(typed ? typed_res : predict_pose(m, x, y, z));
    burst_left--;
    cmds_sent++;
  endtask

  // drop push and wait until every verdict has been popped
  task automatic drain;
    in_push <= 1'b0;
    burst_left = 0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ARM_W-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INNER: arm_inner = v;
      CFG_OUTER: arm_outer = v;
      CFG_HAND:  hand_left = v[0];
      default: ;
    endcase
  endtask

  // mostly well-formed commands inside the work envelope, some raw noise
  task automatic send_random;
    logic [MODE_W-1:0] m;
    logic signed [CW-1:0] x, y, z;
    res_t none;
    none = '0;
    if ($urandom_range(0, 9) < 8) begin
      m = $urandom_range(0, 3);
      do begin
        x = $urandom_range(0, 12798) - 6399;
        y = $urandom_range(0, 12798) - 6399;
      end while (longint'(x) * x + longint'(y) * y >= 40960000);
      z = $urandom_range(161, 3759);
    end else begin
      m = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      x = $urandom; y = $urandom; z = $urandom;
      if ($urandom_range(0, 1) != 0) begin
        x = x >>> 2; y = y >>> 2;
      end
    end
    send_cmd(m, x, y, z, 1'b0, none);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, read at reset arm settings (3200 / 3200 / left)
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [MODE_W-1:0]    m;
    logic signed [CW-1:0] x, y, z;
    bit                   typed;
    reason_t              why;
  } row_t;

  localparam int ROWS = 20;
  row_t plan [ROWS] = '{
    '{8'd255, 15'sd100,    15'sd100,    15'sd1000,   1, RSN_MODE},
    '{8'd4,   15'sd0,      15'sd0,      15'sd0,      1, RSN_MODE},
    '{8'd3,  -15'sd16384, -15'sd16384,  15'sd1000,   1, RSN_RADIUS},
    '{8'd0,   15'sd16383,  15'sd16383, -15'sd16384,  1, RSN_RADIUS},
    '{8'd1,   15'sd6400,   15'sd0,      15'sd1000,   1, RSN_RADIUS},
    '{8'd2,   15'sd3000,   15'sd1000,   15'sd160,    1, RSN_Z},
    '{8'd0,   15'sd3000,   15'sd1000,   15'sd3760,   1, RSN_Z},
    '{8'd0,   15'sd3000,   15'sd1000,  -15'sd16384,  1, RSN_Z},
    '{8'd0,   15'sd3000,   15'sd1000,   15'sd16383,  1, RSN_Z},
    '{8'd0,   15'sd0,      15'sd0,      15'sd1000,   1, RSN_JOINT},
    '{8'd0,   15'sd3000,   15'sd1000,   15'sd161,    0, RSN_OK},
    '{8'd1,   15'sd3000,   15'sd1000,   15'sd3759,   0, RSN_OK},
    '{8'd2,   15'sd6399,   15'sd0,      15'sd2000,   0, RSN_OK},
    '{8'd3,   15'sd4000,   15'sd2000,   15'sd2000,   0, RSN_OK},
    '{8'd0,  -15'sd4000,   15'sd2000,   15'sd2000,   0, RSN_OK},
    '{8'd0,   15'sd2000,  -15'sd4000,   15'sd2000,   0, RSN_OK},
    '{8'd0,   15'sd100,    15'sd0,      15'sd2000,   0, RSN_OK},
    '{8'd0,   15'sd0,      15'sd5000,   15'sd2000,   0, RSN_OK},
    '{8'd0,  -15'sd6000,  -15'sd100,    15'sd2000,   0, RSN_OK},
    '{8'd0,   15'sd3000,   15'sd3000,   15'sd2000,   0, RSN_OK}
  };

  // arm settings per random phase: inner, outer, hand
  localparam int PHASES = 6;
  logic [ARM_W-1:0] ph_inner [PHASES] = '{13'd3200, 13'd0,    13'd8191, 13'd3200, 13'd1,  13'd4000};
  logic [ARM_W-1:0] ph_outer [PHASES] = '{13'd3200, 13'd3200, 13'd8191, 13'd1600, 13'd0,  13'd2400};
  logic             ph_hand  [PHASES] = '{1'b0,     1'b1,     1'b0,     1'b1,     1'b1,   1'b0};

  initial begin
    res_t typed_res;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      typed_res.reason    = plan[i].why;
      typed_res.valid_res = (plan[i].why == RSN_OK);
      send_cmd(plan[i].m, plan[i].x, plan[i].y, plan[i].z, plan[i].typed, typed_res);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_INNER, ph_inner[p]);
      write_reg(CFG_OUTER, ph_outer[p]);
      write_reg(CFG_HAND, ph_hand[p]);
      if (p == 1) begin
        // index 3 is not a register: must leave the arm settings alone
        cfg_we <= 1'b1; cfg_index <= 2'd3; cfg_data <= 13'h1FFF;
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      for (int k = 0; k < 305; k++) begin
        send_random();
        // mid-phase hold-off: let the pipeline run dry once per phase
        if (k == 150) drain();
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d commands over %0d arm settings; %0d verdicts checked, %0d reachable.",
             cmds_sent, PHASES + 1, verdicts_seen, pass_seen);
    if (fails == 0 && verdicts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
hdl/spr_pkg.sv
hdl/spr_front.sv
hdl/spr_fifo.sv
hdl/spr_cordic.sv
hdl/spr_back.sv
hdl/scara_pose_reachability_check.sv
tb/tb.sv
